FILE: rtl/core/qmn_pkg.sv
// ----------------------------------------------------------------------------
// qmn_pkg
// Shared beat types and fixed widths for the normalised quaternion product.
// ----------------------------------------------------------------------------
package qmn_pkg;

    localparam int IN_W  = 16;   // input component width
    localparam int MAG_W = 33;   // magnitude of one product part (at most 2^32)
    localparam int SQ_W  = 66;   // square of a magnitude
    localparam int SUM_W = 67;   // sum of four squares
    localparam int LANES = 4;

    typedef struct packed {
        logic signed [IN_W-1:0] a_x;
        logic signed [IN_W-1:0] a_y;
        logic signed [IN_W-1:0] a_z;
        logic signed [IN_W-1:0] a_w;
        logic signed [IN_W-1:0] b_x;
        logic signed [IN_W-1:0] b_y;
        logic signed [IN_W-1:0] b_z;
        logic signed [IN_W-1:0] b_w;
    } operand_t;

    typedef struct packed {
        logic signed [15:0] r_x;
        logic signed [15:0] r_y;
        logic signed [15:0] r_z;
        logic signed [15:0] r_w;
        logic               zero_length;
    } result_t;

    typedef struct packed {
        logic [LANES-1:0] neg;
        logic             zero;
    } flags_t;

    typedef struct packed {
        flags_t                      flags;
        logic [LANES-1:0][SQ_W-1:0]  sq;
        logic [SUM_W-1:0]            sum;
    } norm_t;

endpackage

FILE: rtl/core/quaternion_multiply_normalize_core.sv
// ----------------------------------------------------------------------------
// quaternion_multiply_normalize_core
// Hamilton product of two Q2.14 quaternions, scaled to unit length with
// round-to-nearest results in Q1.FRAC_BITS.
// ----------------------------------------------------------------------------
// The block takes one quaternion pair per cycle, unless the result beat is
// stalled, and returns one result beat per pair, in order. The pipeline is made
// up of five product stages, the restoring divider, which resolves one of its
// 2*FRAC_BITS + 3 quotient bits per stage, the square-root pipeline, which
// resolves one of its FRAC_BITS + 2 root bits per stage, and the output register.
// When the result beat is stalled the whole pipeline holds. A product of zero
// length returns the identity with zero_length set.
module quaternion_multiply_normalize_core #(
    parameter int FRAC_BITS = 14
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              operand_valid,
    output logic              operand_stall,
    input  qmn_pkg::operand_t operand,
    output logic              result_valid,
    input  logic              result_stall,
    output qmn_pkg::result_t  result
);
    import qmn_pkg::*;

    localparam int QW = 2 * FRAC_BITS + 3;
    localparam int UW = FRAC_BITS + 2;
    localparam logic [31:0] ONE_FULL = 32'd1 << FRAC_BITS;
    localparam logic [15:0] ONE16    = (ONE_FULL > 32'd32767) ? 16'h7FFF : ONE_FULL[15:0];

    logic                        adv;
    logic                        prod_valid;
    norm_t                       prod_data;
    logic                        div_valid;
    logic [LANES-1:0][QW-1:0]    div_quo;
    flags_t                      div_flags;
    logic                        sqrt_valid;
    logic [LANES-1:0][UW-1:0]    sqrt_root;
    flags_t                      sqrt_flags;
    logic signed [15:0]          lane_val [LANES];
    result_t                     result_next;
    result_t                     result_reg;
    logic                        result_valid_reg;

    assign adv           = !(result_valid_reg && result_stall);
    assign operand_stall = !adv;

    qmn_product u_product (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (operand_valid),
        .in_data   (operand),
        .out_valid (prod_valid),
        .out_data  (prod_data)
    );

    qmn_divide #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (prod_valid),
        .in_data   (prod_data),
        .out_valid (div_valid),
        .quo       (div_quo),
        .out_flags (div_flags)
    );

    qmn_isqrt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (div_valid),
        .quo       (div_quo),
        .in_flags  (div_flags),
        .out_valid (sqrt_valid),
        .root      (sqrt_root),
        .out_flags (sqrt_flags)
    );

    // The rounded result is half the root of the quadrupled ratio, rounded up.
    for (genvar l = 0; l < LANES; l++)
    begin : g_fmt
        logic [UW:0]   u_inc;
        logic [31:0]   q32;
        logic [15:0]   mag16;

        assign u_inc = {1'b0, sqrt_root[l]} + (UW + 1)'(1);
        assign q32   = 32'(u_inc[UW:1]);
        assign mag16 = (q32 > 32'd32767) ? 16'h7FFF : q32[15:0];
        assign lane_val[l] = sqrt_flags.neg[l] ? 16'(16'd0 - mag16) : mag16;
    end

    always_comb
    begin
        if (sqrt_flags.zero)
        begin
            result_next.r_x = '0;
            result_next.r_y = '0;
            result_next.r_z = '0;
            result_next.r_w = ONE16;
        end
        else
        begin
            result_next.r_x = lane_val[0];
            result_next.r_y = lane_val[1];
            result_next.r_z = lane_val[2];
            result_next.r_w = lane_val[3];
        end
        result_next.zero_length = sqrt_flags.zero;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            result_valid_reg <= sqrt_valid;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: rtl/core/qmn_product.sv
// ----------------------------------------------------------------------------
// qmn_product
// Hamilton product, part magnitudes, their squares and the squared length,
// over five register stages.
// ----------------------------------------------------------------------------
module qmn_product (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  qmn_pkg::operand_t in_data,
    output logic             out_valid,
    output qmn_pkg::norm_t   out_data
);
    import qmn_pkg::*;

    localparam int P_W = MAG_W + 1;

    logic signed [31:0]      prod_next [LANES][4];
    logic signed [31:0]      prod_reg  [LANES][4];
    logic signed [P_W-1:0]   part_reg  [LANES];
    logic [MAG_W-1:0]        mag_reg   [LANES];
    logic [LANES-1:0]        neg3_reg;
    logic [LANES-1:0]        neg4_reg;
    logic [SQ_W-1:0]         sq_reg    [LANES];
    logic [SUM_W-1:0]        sum_next;
    norm_t                   out_reg;
    logic [4:0]              vld_reg;

    always_comb
    begin
        prod_next[0][0] = 32'(in_data.a_w * in_data.b_x);
        prod_next[0][1] = 32'(in_data.b_w * in_data.a_x);
        prod_next[0][2] = 32'(in_data.a_y * in_data.b_z);
        prod_next[0][3] = 32'(in_data.a_z * in_data.b_y);
        prod_next[1][0] = 32'(in_data.a_w * in_data.b_y);
        prod_next[1][1] = 32'(in_data.b_w * in_data.a_y);
        prod_next[1][2] = 32'(in_data.a_z * in_data.b_x);
        prod_next[1][3] = 32'(in_data.a_x * in_data.b_z);
        prod_next[2][0] = 32'(in_data.a_w * in_data.b_z);
        prod_next[2][1] = 32'(in_data.b_w * in_data.a_z);
        prod_next[2][2] = 32'(in_data.a_x * in_data.b_y);
        prod_next[2][3] = 32'(in_data.a_y * in_data.b_x);
        prod_next[3][0] = 32'(in_data.a_w * in_data.b_w);
        prod_next[3][1] = 32'(in_data.a_x * in_data.b_x);
        prod_next[3][2] = 32'(in_data.a_y * in_data.b_y);
        prod_next[3][3] = 32'(in_data.a_z * in_data.b_z);
    end

    assign sum_next = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1])
                    + SUM_W'(sq_reg[2]) + SUM_W'(sq_reg[3]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            for (int l = 0; l < LANES; l++)
            begin
                // The scalar lane subtracts the dot product; vector lanes add the cross term.
                if (l == LANES - 1)
                begin
                    part_reg[l] <= P_W'(prod_reg[l][0]) - P_W'(prod_reg[l][1])
                                 - P_W'(prod_reg[l][2]) - P_W'(prod_reg[l][3]);
                end
                else
                begin
                    part_reg[l] <= P_W'(prod_reg[l][0]) + P_W'(prod_reg[l][1])
                                 + P_W'(prod_reg[l][2]) - P_W'(prod_reg[l][3]);
                end
                neg3_reg[l] <= part_reg[l][P_W-1];
                mag_reg[l]  <= part_reg[l][P_W-1] ? MAG_W'(-part_reg[l])
                                                  : MAG_W'(part_reg[l]);
                sq_reg[l]   <= SQ_W'(mag_reg[l] * mag_reg[l]);
                out_reg.sq[l] <= sq_reg[l];
            end
            neg4_reg          <= neg3_reg;
            out_reg.flags.neg <= neg4_reg;
            out_reg.sum       <= sum_next;
            out_reg.flags.zero <= (sum_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    assign out_valid = vld_reg[4];
    assign out_data  = out_reg;

endmodule

FILE: rtl/core/qmn_divide.sv
// ----------------------------------------------------------------------------
// qmn_divide
// Restoring division of each scaled square by the squared length, one
// quotient bit per register stage, four lanes side by side.
// ----------------------------------------------------------------------------
module qmn_divide #(
    parameter  int FRAC_BITS = 14,
    localparam int QW        = 2 * FRAC_BITS + 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                in_valid,
    input  qmn_pkg::norm_t                      in_data,
    output logic                                out_valid,
    output logic [qmn_pkg::LANES-1:0][QW-1:0]   quo,
    output qmn_pkg::flags_t                     out_flags
);
    import qmn_pkg::*;

    localparam int RW = SUM_W;

    logic [RW-1:0]    rem_reg  [QW-1][LANES];
    logic [QW-1:0]    quo_reg  [QW][LANES];
    logic [SUM_W-1:0] sum_reg  [QW-1];
    flags_t           flags_reg [QW];
    logic [QW-1:0]    vld_reg;

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [RW:0]      cur     [LANES];
        logic [QW-1:0]    quo_in  [LANES];
        logic [SUM_W-1:0] sum_in;
        flags_t           flags_in;
        logic             vld_in;

        if (k == 0)
        begin : g_first
            // The square never exceeds the squared length, so it is already below 2s.
            for (genvar l = 0; l < LANES; l++)
            begin : g_lane
                assign cur[l]    = (RW + 1)'(in_data.sq[l]);
                assign quo_in[l] = '0;
            end
            assign sum_in   = in_data.sum;
            assign flags_in = in_data.flags;
            assign vld_in   = in_valid;
        end
        else
        begin : g_next
            for (genvar l = 0; l < LANES; l++)
            begin : g_lane
                assign cur[l]    = {rem_reg[k-1][l], 1'b0};
                assign quo_in[l] = quo_reg[k-1][l];
            end
            assign sum_in   = sum_reg[k-1];
            assign flags_in = flags_reg[k-1];
            assign vld_in   = vld_reg[k-1];
        end

        for (genvar l = 0; l < LANES; l++)
        begin : g_step
            logic          fits;
            logic [RW:0]   diff;

            assign fits = (cur[l] >= (RW + 1)'(sum_in));
            assign diff = cur[l] - (RW + 1)'(sum_in);

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    quo_reg[k][l] <= {quo_in[l][QW-2:0], fits};
                end
            end

            if (k < QW - 1)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        rem_reg[k][l] <= fits ? diff[RW-1:0] : cur[l][RW-1:0];
                    end
                end
            end
        end

        if (k < QW - 1)
        begin : g_sum
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sum_reg[k] <= sum_in;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                flags_reg[k] <= flags_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k] <= vld_in;
            end
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_out
        assign quo[l] = quo_reg[QW-1][l];
    end

    assign out_valid = vld_reg[QW-1];
    assign out_flags = flags_reg[QW-1];

endmodule

FILE: rtl/core/qmn_isqrt.sv
// ----------------------------------------------------------------------------
// qmn_isqrt
// Integer square root of each quotient, one root bit per register stage,
// four lanes side by side.
// ----------------------------------------------------------------------------
module qmn_isqrt #(
    parameter  int FRAC_BITS = 14,
    localparam int QW        = 2 * FRAC_BITS + 3,
    localparam int UW        = FRAC_BITS + 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic [qmn_pkg::LANES-1:0][QW-1:0]   quo,
    input  qmn_pkg::flags_t                     in_flags,
    output logic                                out_valid,
    output logic [qmn_pkg::LANES-1:0][UW-1:0]   root,
    output qmn_pkg::flags_t                     out_flags
);
    import qmn_pkg::*;

    localparam int DW  = 2 * UW;
    localparam int RMW = UW + 2;
    localparam int AW  = UW + 4;

    logic [DW-1:0]  d_reg    [UW-1][LANES];
    logic [RMW-1:0] rem_reg  [UW-1][LANES];
    logic [UW-1:0]  root_reg [UW][LANES];
    flags_t         flags_reg [UW];
    logic [UW-1:0]  vld_reg;

    for (genvar k = 0; k < UW; k++)
    begin : g_stage
        logic [DW-1:0]  d_in    [LANES];
        logic [RMW-1:0] rem_in  [LANES];
        logic [UW-1:0]  root_in [LANES];
        flags_t         flags_in;
        logic           vld_in;

        if (k == 0)
        begin : g_first
            for (genvar l = 0; l < LANES; l++)
            begin : g_lane
                assign d_in[l]    = DW'(quo[l]);
                assign rem_in[l]  = '0;
                assign root_in[l] = '0;
            end
            assign flags_in = in_flags;
            assign vld_in   = in_valid;
        end
        else
        begin : g_next
            for (genvar l = 0; l < LANES; l++)
            begin : g_lane
                assign d_in[l]    = d_reg[k-1][l];
                assign rem_in[l]  = rem_reg[k-1][l];
                assign root_in[l] = root_reg[k-1][l];
            end
            assign flags_in = flags_reg[k-1];
            assign vld_in   = vld_reg[k-1];
        end

        for (genvar l = 0; l < LANES; l++)
        begin : g_step
            logic [AW-1:0] acc;
            logic [AW-1:0] trial;
            logic [AW-1:0] diff;
            logic          fits;

            // Bring down the next two radicand bits and try the root bit as one.
            assign acc   = {rem_in[l], d_in[l][DW-1:DW-2]};
            assign trial = AW'({root_in[l], 2'b01});
            assign fits  = (acc >= trial);
            assign diff  = acc - trial;

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    root_reg[k][l] <= {root_in[l][UW-2:0], fits};
                end
            end

            if (k < UW - 1)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        rem_reg[k][l] <= fits ? diff[RMW-1:0] : acc[RMW-1:0];
                        d_reg[k][l]   <= {d_in[l][DW-3:0], 2'b00};
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                flags_reg[k] <= flags_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k] <= vld_in;
            end
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_out
        assign root[l] = root_reg[UW-1][l];
    end

    assign out_valid = vld_reg[UW-1];
    assign out_flags = flags_reg[UW-1];

endmodule

FILE: tb/tb_quaternion_multiply_normalize_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_multiply_normalize_core
// Self-checking bench for the normalised Hamilton product. A short table of
// directed pairs is followed by random pairs. Every result beat is compared
// with an exact integer prediction, under random idling and stalls.
// ----------------------------------------------------------------------------
module tb_quaternion_multiply_normalize_core;
    import qmn_pkg::*;

    localparam int FRAC       = 14;
    localparam int LATENCY    = 3 * FRAC + 11;
    localparam int N_RANDOM   = 1630;
    localparam int HOLD_LEN   = 300;

    typedef struct {
        operand_t op;
        bit       known;
        result_t  res;
    } vector_t;

    logic     clk;
    logic     rst_n;
    logic     operand_valid;
    logic     operand_stall;
    operand_t operand;
    logic     result_valid;
    logic     result_stall;
    result_t  result;

    result_t  pending_results[$];
    int       mismatches;
    int       beats_in;
    int       beats_out;
    int       zero_seen;
    bit       hold_request;
    bit       stim_done;

    quaternion_multiply_normalize_core #(.FRAC_BITS(FRAC)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .operand_valid (operand_valid),
        .operand_stall (operand_stall),
        .operand       (operand),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Exact Hamilton product, then each part scaled by the length with ties
    // rounded away from zero, found by a bisection on squared comparisons.
    function automatic result_t predict_unit_product(operand_t op);
        longint           ax, ay, az, aw, bx, by, bz, bw;
        longint           p[4];
        longint unsigned  m;
        logic [127:0]     sum_sq;
        logic [127:0]     lhs;
        logic [127:0]     rhs;
        longint unsigned  lo, hi, mid, t;
        logic [15:0]      r[4];
        result_t          res;
        ax = op.a_x; ay = op.a_y; az = op.a_z; aw = op.a_w;
        bx = op.b_x; by = op.b_y; bz = op.b_z; bw = op.b_w;
        p[0] = aw * bx + bw * ax + (ay * bz - az * by);
        p[1] = aw * by + bw * ay + (az * bx - ax * bz);
        p[2] = aw * bz + bw * az + (ax * by - ay * bx);
        p[3] = aw * bw - ax * bx - ay * by - az * bz;
        sum_sq = '0;
        for (int i = 0; i < 4; i++)
        begin
            m = (p[i] < 0) ? longint'(-p[i]) : longint'(p[i]);
            sum_sq += 128'(m) * 128'(m);
        end
        if (sum_sq == 0)
        begin
            res.r_x = '0;
            res.r_y = '0;
            res.r_z = '0;
            res.r_w = 16'(1 << FRAC);
            res.zero_length = 1'b1;
            return res;
        end
        for (int i = 0; i < 4; i++)
        begin
            m = (p[i] < 0) ? longint'(-p[i]) : longint'(p[i]);
            lhs = (128'(m) * 128'(m)) << (2 * FRAC + 2);
            lo = 0;
            hi = 64'd1 << FRAC;
            while (lo < hi)
            begin
                mid = lo + (hi - lo + 1) / 2;
                t = 2 * mid - 1;
                rhs = 128'(t * t) * sum_sq;
                if (rhs <= lhs)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            if (lo > 32767)
                lo = 32767;
            r[i] = (p[i] < 0) ? 16'(-lo) : 16'(lo);
        end
        res.r_x = r[0];
        res.r_y = r[1];
        res.r_z = r[2];
        res.r_w = r[3];
        res.zero_length = 1'b0;
        return res;
    endfunction

    function automatic logic [15:0] random_component();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'(int'($urandom_range(0, 6)) - 3);
            3:       return 16'(int'($urandom_range(0, 32768)) - 16384);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic operand_t random_pair();
        operand_t op;
        op = {$urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(0, 3) != 0)
        begin
            op.a_x = random_component(); op.a_y = random_component();
            op.a_z = random_component(); op.a_w = random_component();
            op.b_x = random_component(); op.b_y = random_component();
            op.b_z = random_component(); op.b_w = random_component();
        end
        // A zero factor gives a zero-length product.
        case ($urandom_range(0, 39))
            0: begin op.a_x = '0; op.a_y = '0; op.a_z = '0; op.a_w = '0; end
            1: begin op.b_x = '0; op.b_y = '0; op.b_z = '0; op.b_w = '0; end
            default: ;
        endcase
        return op;
    endfunction

    function automatic int random_gap();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return 0;
        else if (sel < 95)
            return $urandom_range(1, 4);
        else
            return $urandom_range(10, 80);
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // Drives one beat and returns at the edge where it is taken.
    task automatic send_beat(operand_t op);
        bit taken;
        operand <= op;
        operand_valid <= 1'b1;
        forever
        begin
            @(negedge clk);
            taken = !operand_stall;
            @(posedge clk);
            if (taken)
                break;
        end
    endtask

    task automatic idle_gap(int cycles);
        if (cycles > 0)
        begin
            operand_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Counts the operand beats that the block has taken.
    always @(posedge clk)
    begin
        if (rst_n && operand_valid && !operand_stall)
            beats_in <= beats_in + 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            beats_out <= beats_out + 1;
            if (result.zero_length)
                zero_seen <= zero_seen + 1;
            if (pending_results.size() == 0)
            begin
                $error("result beat arrived with nothing outstanding");
                mismatches++;
            end
            else
            begin
                result_t want;
                want = pending_results.pop_front();
                check_field("r_x", want.r_x, result.r_x);
                check_field("r_y", want.r_y, result.r_y);
                check_field("r_z", want.r_z, result.r_z);
                check_field("r_w", want.r_w, result.r_w);
                check_field("zero_length", want.zero_length, result.zero_length);
            end
        end
    end

    // Receiver: random stall, with one long hold-off on request.
    initial
    begin
        int stall_run;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_LEN - 1) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (stim_done || beats_in < 200 || (beats_in > 900 && beats_in < 1100))
                result_stall <= 1'b0;
            else
            begin
                stall_run = random_gap();
                result_stall <= (stall_run != 0);
                if (stall_run > 1)
                    repeat (stall_run - 1) @(posedge clk);
            end
        end
    end

    initial
    begin
        vector_t  table_rows[$];
        vector_t  row;
        operand_t op;
        int       drain;
        mismatches   = 0;
        beats_in     = 0;
        beats_out    = 0;
        zero_seen    = 0;
        hold_request = 1'b0;
        stim_done    = 1'b0;
        rst_n         = 1'b0;
        operand_valid = 1'b0;
        operand       = '0;

        // Directed rows: x, y, z, w of a then of b.
        row.known = 1'b1;
        row.op = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
        row.res = '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b1};
        table_rows.push_back(row);
        row.op = '{16'sd0, 16'sd0, 16'sd0, 16'sd0,
                   -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767};
        table_rows.push_back(row);
        row.op = '{16'sd32767, -16'sd32768, 16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
        table_rows.push_back(row);
        row.op = '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384};
        row.res = '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b0};
        table_rows.push_back(row);
        row.op = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0};
        row.res = '{16'sd0, 16'sd0, 16'sd0, -16'sd16384, 1'b0};
        table_rows.push_back(row);
        row.op = '{16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd0};
        row.res = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0};
        table_rows.push_back(row);
        row.op = '{16'sd0, 16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd0};
        row.res = '{16'sd0, 16'sd0, -16'sd16384, 16'sd0, 1'b0};
        table_rows.push_back(row);
        row.known = 1'b0;
        row.op = '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                   16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767};
        table_rows.push_back(row);
        row.op = '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                   -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768};
        table_rows.push_back(row);
        row.op = '{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
                   -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767};
        table_rows.push_back(row);
        row.op = '{-16'sd1, -16'sd1, -16'sd1, -16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1};
        table_rows.push_back(row);
        row.op = '{16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6, 16'sd7, 16'sd8};
        table_rows.push_back(row);
        row.op = '{16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 16'sd0, 16'sd11585, 16'sd0, 16'sd11585};
        table_rows.push_back(row);
        row.op = '{16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd0};
        table_rows.push_back(row);

        repeat (4) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        foreach (table_rows[i])
        begin
            pending_results.push_back(table_rows[i].known ? table_rows[i].res
                                      : predict_unit_product(table_rows[i].op));
            send_beat(table_rows[i].op);
            idle_gap(random_gap());
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 300)
                hold_request = 1'b1;
            if (n == 800)
            begin
                // Let the pipeline run dry before carrying on.
                idle_gap(1);
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            op = random_pair();
            pending_results.push_back(predict_unit_product(op));
            if (n >= 300 && n < 380)
                send_beat(op);
            else
            begin
                send_beat(op);
                idle_gap(random_gap());
            end
        end
        operand_valid <= 1'b0;
        stim_done = 1'b1;

        drain = 0;
        while (pending_results.size() != 0 && drain < 100000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (LATENCY + 10) @(posedge clk);

        $display("Sent %0d operand pairs and checked %0d result beats, %0d of zero length.",
                 beats_in, beats_out, zero_seen);
        $display("Directed extremes, random pairs, a long output hold-off and a full drain.");
        if (mismatches == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
